### hw/rtl/assert_macros.svh
// Assertion helpers shared by the RTL files that carry checks.
// Every check is sampled on the rising edge of clk and is off during rst.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property that must hold at every edge out of reset.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Antecedent in this cycle implies consequent in the same cycle.
`define ASSERT_IMPLIES(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

`endif

### hw/rtl/cfcc_pkg.sv
// ---------------------------------------------------------------------------
// cfcc_pkg
// Types, constants and the CRC8H2F byte update for the CAN frame checker.
// ---------------------------------------------------------------------------
package cfcc_pkg;

  // Frame layout: bytes 0..8 carry data, byte 9 carries the CRC
  localparam logic [3:0] FRAME_LAST_POS = 4'd9;

  // CRC8H2F: poly 0x2F, init 0xFF, final xor 0xFF, not reflected
  localparam logic [7:0] CRC_POLY   = 8'h2F;
  localparam logic [7:0] CRC_INIT   = 8'hFF;
  localparam logic [7:0] CRC_XOROUT = 8'hFF;

  // Configuration register indexes and reset values
  localparam int unsigned CFG_INDEX_W   = 2;
  localparam int unsigned CFG_DATA_W    = 16;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_FRAME_ID = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_IDX_STEP     = 2'd1;
  localparam logic [15:0] FRAME_ID_RESET = 16'h021A;
  localparam logic [7:0]  STEP_RESET     = 8'd10;

  // Record kinds
  localparam logic REC_LOG     = 1'b0;
  localparam logic REC_CRC_ERR = 1'b1;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       datagram_start;
  } cfcc_in_t;

  typedef struct packed {
    logic        record_kind;
    logic [23:0] mileage_value;
    logic [29:0] speed_tenths_kmh;
  } cfcc_out_t;

  // Completed frame with the accepted id, handed to the filter
  typedef struct packed {
    logic        crc_ok;
    logic [23:0] mileage;
    logic [23:0] speed;
  } cfcc_event_t;

  // Feed one byte into the CRC, MSB first
  function automatic logic [7:0] crc8_feed(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ({c[6:0], 1'b0} ^ CRC_POLY) : {c[6:0], 1'b0};
    end
    return c;
  endfunction

endpackage

### hw/rtl/cfcc_frame.sv
// ---------------------------------------------------------------------------
// cfcc_frame
// Byte-wise frame assembler: tracks frame position, runs the CRC, shifts in
// id, mileage and speed, and posts an event for each finished frame whose
// id matches the configured one.
// ---------------------------------------------------------------------------
module cfcc_frame (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  cfcc_pkg::cfcc_in_t   in_data,
  input  logic [15:0]          frame_id_cfg,
  output logic                 ev_valid,
  input  logic                 ev_ready,
  output cfcc_pkg::cfcc_event_t ev
);

  logic [3:0]  byte_position, byte_position_next;
  logic [7:0]  running_crc, running_crc_next;
  logic [15:0] frame_id_shift, frame_id_shift_next;
  logic [23:0] frame_mileage_shift, frame_mileage_shift_next;
  logic [23:0] frame_speed_shift, frame_speed_shift_next;
  logic        ev_valid_next;
  cfcc_pkg::cfcc_event_t ev_next;

  logic [3:0] pos;
  logic [7:0] crc_base;
  logic       accept;
  logic       new_ev;

  // Take a byte unless a finished frame still waits for the filter
  assign in_ready = !ev_valid || ev_ready;
  assign accept   = in_valid && in_ready;

  // Resolve position, run the CRC and shift the fields
  always_comb begin
    pos = in_data.datagram_start ? 4'd0 : byte_position;
    if (pos > cfcc_pkg::FRAME_LAST_POS) begin
      pos = 4'd0;
    end
    crc_base = (pos == 4'd0) ? cfcc_pkg::CRC_INIT : running_crc;

    byte_position_next       = byte_position;
    running_crc_next         = running_crc;
    frame_id_shift_next      = frame_id_shift;
    frame_mileage_shift_next = frame_mileage_shift;
    frame_speed_shift_next   = frame_speed_shift;
    new_ev                   = 1'b0;
    ev_next                  = ev;

    if (accept) begin
      running_crc_next = crc_base;
      if (pos < cfcc_pkg::FRAME_LAST_POS) begin
        running_crc_next   = cfcc_pkg::crc8_feed(crc_base, in_data.data_byte);
        byte_position_next = pos + 4'd1;
        if (pos <= 4'd1) begin
          frame_id_shift_next = {frame_id_shift[7:0], in_data.data_byte};
        end else if (pos >= 4'd3 && pos <= 4'd5) begin
          frame_mileage_shift_next = {frame_mileage_shift[15:0], in_data.data_byte};
        end else if (pos >= 4'd6) begin
          frame_speed_shift_next = {frame_speed_shift[15:0], in_data.data_byte};
        end
      end else begin
        // CRC byte: close the frame, post it only for the accepted id
        byte_position_next = 4'd0;
        if (frame_id_shift == frame_id_cfg) begin
          new_ev         = 1'b1;
          ev_next.crc_ok = ((running_crc ^ cfcc_pkg::CRC_XOROUT) == in_data.data_byte);
          ev_next.mileage = frame_mileage_shift;
          ev_next.speed   = frame_speed_shift;
        end
      end
    end

    ev_valid_next = (ev_valid && !ev_ready) || new_ev;
  end

  // Hold frame state and the pending event
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_position       <= 4'd0;
      running_crc         <= cfcc_pkg::CRC_INIT;
      frame_id_shift      <= 16'd0;
      frame_mileage_shift <= 24'd0;
      frame_speed_shift   <= 24'd0;
      ev_valid            <= 1'b0;
    end else begin
      byte_position       <= byte_position_next;
      running_crc         <= running_crc_next;
      frame_id_shift      <= frame_id_shift_next;
      frame_mileage_shift <= frame_mileage_shift_next;
      frame_speed_shift   <= frame_speed_shift_next;
      ev_valid            <= ev_valid_next;
    end
  end

  // Event payload needs no reset
  always_ff @(posedge clk) begin
    ev <= ev_next;
  end

endmodule

### hw/rtl/cfcc_filter.sv
// ---------------------------------------------------------------------------
// cfcc_filter
// Log filter: turns a finished frame into an error record, a mileage log
// record or nothing, tracks the last logged mileage and holds the result
// item in the output register.
// ---------------------------------------------------------------------------
module cfcc_filter (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  ev_valid,
  output logic                  ev_ready,
  input  cfcc_pkg::cfcc_event_t ev,
  input  logic [7:0]            mileage_step,
  output logic                  out_valid,
  input  logic                  out_ready,
  output cfcc_pkg::cfcc_out_t   out_data
);

  logic [23:0] last_logged_mileage, last_logged_mileage_next;
  logic        anything_logged, anything_logged_next;
  logic        out_valid_next;
  cfcc_pkg::cfcc_out_t out_data_next;

  logic        take;
  logic [24:0] target;
  logic [29:0] speed_ext;

  // Output register is free when empty or being drained
  assign ev_ready = !out_valid || out_ready;
  assign take     = ev_valid && ev_ready;

  // Mileage target in 25 bits so a sum past 24 bits never matches
  assign target    = {1'b0, last_logged_mileage} + {17'd0, mileage_step};
  assign speed_ext = {6'd0, ev.speed};

  // Decide the record
  always_comb begin
    last_logged_mileage_next = last_logged_mileage;
    anything_logged_next     = anything_logged;
    out_valid_next           = out_valid && !out_ready;
    out_data_next            = out_data;

    if (take) begin
      if (!ev.crc_ok) begin
        out_valid_next                 = 1'b1;
        out_data_next.record_kind      = cfcc_pkg::REC_CRC_ERR;
        out_data_next.mileage_value    = 24'd0;
        out_data_next.speed_tenths_kmh = 30'd0;
      end else if (!anything_logged || ({1'b0, ev.mileage} == target)) begin
        out_valid_next                 = 1'b1;
        out_data_next.record_kind      = cfcc_pkg::REC_LOG;
        out_data_next.mileage_value    = ev.mileage;
        // speed * 36 = speed * 32 + speed * 4
        out_data_next.speed_tenths_kmh = (speed_ext << 5) + (speed_ext << 2);
        last_logged_mileage_next       = ev.mileage;
        anything_logged_next           = 1'b1;
      end
    end
  end

  // Hold log history and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      last_logged_mileage <= 24'd0;
      anything_logged     <= 1'b0;
      out_valid           <= 1'b0;
    end else begin
      last_logged_mileage <= last_logged_mileage_next;
      anything_logged     <= anything_logged_next;
      out_valid           <= out_valid_next;
    end
  end

  // Result payload needs no reset
  always_ff @(posedge clk) begin
    out_data <= out_data_next;
  end

endmodule

### hw/rtl/can_frame_crc_check_and_log_filter_top.sv
// Data path: the accepted CRC byte (byte 9) registers a frame event in the assembler;
// with the output register free, the filter then registers the result item there.
// Throughput: one byte item per cycle; the frame assembler and the filter each hold one
// frame, so input stalls only while a finished frame waits on a stalled output register.
// Reset (rst, synchronous, active high): frame position 0, CRC 0xFF, no log history,
// output empty, accepted_frame_id = 0x21A, mileage_step = 10.
// ---------------------------------------------------------------------------
// can_frame_crc_check_and_log_filter_top
// CAN frame CRC8H2F checker with a mileage log filter over a byte stream.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module can_frame_crc_check_and_log_filter_top (
  input  logic                                  clk,
  input  logic                                  rst,
  input  logic                                  in_valid,
  output logic                                  in_ready,
  input  cfcc_pkg::cfcc_in_t                    in_data,
  output logic                                  out_valid,
  input  logic                                  out_ready,
  output cfcc_pkg::cfcc_out_t                   out_data,
  input  logic                                  cfg_write_en,
  input  logic [cfcc_pkg::CFG_INDEX_W-1:0]      cfg_index,
  input  logic [cfcc_pkg::CFG_DATA_W-1:0]       cfg_data
);

  logic [15:0] accepted_frame_id;
  logic [7:0]  mileage_step;

  logic                  ev_valid;
  logic                  ev_ready;
  cfcc_pkg::cfcc_event_t ev;

  // Write configuration registers, ignore unknown indexes
  always_ff @(posedge clk) begin
    if (rst) begin
      accepted_frame_id <= cfcc_pkg::FRAME_ID_RESET;
      mileage_step      <= cfcc_pkg::STEP_RESET;
    end else if (cfg_write_en) begin
      unique case (cfg_index)
        cfcc_pkg::CFG_IDX_FRAME_ID: accepted_frame_id <= cfg_data[15:0];
        cfcc_pkg::CFG_IDX_STEP:     mileage_step      <= cfg_data[7:0];
        default: ;
      endcase
    end
  end

  // Assemble frames and run the CRC
  cfcc_frame u_frame (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .frame_id_cfg (accepted_frame_id),
    .ev_valid     (ev_valid),
    .ev_ready     (ev_ready),
    .ev           (ev)
  );

  // Filter frames into result items
  cfcc_filter u_filter (
    .clk          (clk),
    .rst          (rst),
    .ev_valid     (ev_valid),
    .ev_ready     (ev_ready),
    .ev           (ev),
    .mileage_step (mileage_step),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data)
  );

  // Input stalls only behind a pending frame
  `ASSERT_IMPLIES(a_stall_needs_event, !in_ready, ev_valid, "input stalled with no pending frame")

  // An error record carries zero fields
  `ASSERT_IMPLIES(a_err_fields_zero,
    out_valid && out_data.record_kind == cfcc_pkg::REC_CRC_ERR,
    out_data.mileage_value == 24'd0 && out_data.speed_tenths_kmh == 30'd0,
    "error record with nonzero fields")

  // A new frame event follows an accepted byte
  `ASSERT_ALWAYS(a_event_from_byte,
    !$rose(ev_valid) || $past(in_valid && in_ready),
    "frame event without an accepted item")

  // A fresh result item follows a taken frame event
  `ASSERT_ALWAYS(a_result_from_event,
    !$rose(out_valid) || $past(ev_valid && ev_ready),
    "result item without a frame event")

endmodule

### verif/can_frame_crc_check_and_log_filter_top_tb.sv
// ----------------------------------------------------------------------------
// CAN frame CRC checker and mileage log filter testbench
// Streams byte items cut into 10-byte frames through the block, predicts every
// log and CRC error record in step with the accepted bytes, and checks each
// result item field by field under random gaps and back-pressure.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module can_frame_crc_check_and_log_filter_top_tb;

  localparam int CLK_PERIOD     = 12;
  localparam int RESET_CYCLES   = 12;
  localparam int SETTLE_CYCLES  = 10;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int MAX_REPORTS    = 10;

  localparam logic [29:0] SPEED_FACTOR = 30'd36;
  // First logged mileage sits near the top so the step sum runs past range late
  localparam logic [23:0] FIRST_LOG_MILEAGE = 24'hFFF800;
  // Indexes that decode to no register
  localparam logic [cfcc_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_LO = 2'd2;
  localparam logic [cfcc_pkg::CFG_INDEX_W-1:0] CFG_IDX_SPARE_HI = 2'd3;

  logic                             clk = 1'b0;
  logic                             rst = 1'b1;
  logic                             in_valid = 1'b0;
  logic                             in_ready;
  cfcc_pkg::cfcc_in_t               in_data = '0;
  logic                             out_valid;
  logic                             out_ready = 1'b0;
  cfcc_pkg::cfcc_out_t              out_data;
  logic                             cfg_write_en = 1'b0;
  logic [cfcc_pkg::CFG_INDEX_W-1:0] cfg_index = '0;
  logic [cfcc_pkg::CFG_DATA_W-1:0]  cfg_data = '0;

  // Frame assembly and log filter state, tracked on accepted bytes
  logic [3:0]  asm_pos = '0;
  logic [7:0]  asm_crc = cfcc_pkg::CRC_INIT;
  logic [15:0] asm_id = '0;
  logic [23:0] asm_mileage = '0;
  logic [23:0] asm_speed = '0;
  logic [23:0] last_mileage = '0;
  logic        have_logged = 1'b0;
  logic [15:0] cfg_frame_id = cfcc_pkg::FRAME_ID_RESET;
  logic [7:0]  cfg_step = cfcc_pkg::STEP_RESET;

  cfcc_pkg::cfcc_out_t expected_records[$];
  int        mismatch_count = 0;
  int        bytes_accepted = 0;
  int        stall_cycles = 0;
  bit        realign_next = 1'b0;
  int        send_calm_left = 0;
  int        recv_calm_left = 0;
  int        recv_stall_left = 0;

  can_frame_crc_check_and_log_filter_top dut (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_data      (in_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_data     (out_data),
    .cfg_write_en (cfg_write_en),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // CRC8H2F update, one data bit at a time from the MSB
  function automatic logic [7:0] crc8h2f_step(input logic [7:0] crc, input logic [7:0] b);
    logic feedback;
    for (int i = 7; i >= 0; i--) begin
      feedback = crc[7] ^ b[i];
      crc = {crc[6:0], 1'b0} ^ (feedback ? cfcc_pkg::CRC_POLY : 8'h00);
    end
    return crc;
  endfunction

  // Advance frame assembly by one byte; queue a record when a frame closes
  task automatic predict_byte(input cfcc_pkg::cfcc_in_t item);
    logic [3:0]          pos;
    logic [24:0]         target;
    cfcc_pkg::cfcc_out_t rec;
    pos = item.datagram_start ? 4'd0 : asm_pos;
    if (pos > cfcc_pkg::FRAME_LAST_POS) pos = 4'd0;
    if (pos == 4'd0) asm_crc = cfcc_pkg::CRC_INIT;
    if (pos < cfcc_pkg::FRAME_LAST_POS) begin
      asm_crc = crc8h2f_step(asm_crc, item.data_byte);
      if (pos <= 4'd1) asm_id = {asm_id[7:0], item.data_byte};
      else if (pos >= 4'd3 && pos <= 4'd5) asm_mileage = {asm_mileage[15:0], item.data_byte};
      else if (pos >= 4'd6) asm_speed = {asm_speed[15:0], item.data_byte};
      asm_pos = pos + 4'd1;
    end else begin
      asm_pos = 4'd0;
      if (asm_id == cfg_frame_id) begin
        if ((asm_crc ^ cfcc_pkg::CRC_XOROUT) == item.data_byte) begin
          // Compare against the step sum in 25 bits, no wrap
          target = {1'b0, last_mileage} + 25'(cfg_step);
          if (!have_logged || {1'b0, asm_mileage} == target) begin
            last_mileage = asm_mileage;
            have_logged = 1'b1;
            rec.record_kind = cfcc_pkg::REC_LOG;
            rec.mileage_value = asm_mileage;
            rec.speed_tenths_kmh = 30'(asm_speed) * SPEED_FACTOR;
            expected_records.push_back(rec);
          end
        end else begin
          rec.record_kind = cfcc_pkg::REC_CRC_ERR;
          rec.mileage_value = '0;
          rec.speed_tenths_kmh = '0;
          expected_records.push_back(rec);
        end
      end
    end
  endtask

  // Sender idle length: mostly none, some short, a few long, with calm stretches
  function automatic int sender_gap();
    int r;
    if (send_calm_left > 0) begin
      send_calm_left--;
      return 0;
    end
    r = $urandom_range(0, 99);
    if (r < 3) begin
      send_calm_left = $urandom_range(20, 80);
      return 0;
    end
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Present one byte item and hold it until accepted
  task automatic send_item(input logic [7:0] b, input logic start);
    int gap;
    gap = sender_gap();
    if (gap > 0) begin
      @(negedge clk);
      in_valid = 1'b0;
      in_data = cfcc_pkg::cfcc_in_t'($urandom);
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid = 1'b1;
    in_data.data_byte = b;
    in_data.datagram_start = start;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    bytes_accepted++;
    predict_byte(in_data);
  endtask

  // Build a frame and send its first n_bytes
  task automatic send_frame(input logic [15:0] id, input logic [23:0] mileage,
                            input logic [23:0] speed, input bit crc_good, input int n_bytes);
    logic [7:0] frame [0:9];
    logic [7:0] crc;
    frame[0] = id[15:8];
    frame[1] = id[7:0];
    frame[2] = 8'($urandom);
    frame[3] = mileage[23:16];
    frame[4] = mileage[15:8];
    frame[5] = mileage[7:0];
    frame[6] = speed[23:16];
    frame[7] = speed[15:8];
    frame[8] = speed[7:0];
    crc = cfcc_pkg::CRC_INIT;
    for (int i = 0; i < 9; i++) crc = crc8h2f_step(crc, frame[i]);
    crc = crc ^ cfcc_pkg::CRC_XOROUT;
    frame[9] = crc_good ? crc : crc ^ 8'($urandom_range(1, 255));
    for (int i = 0; i < n_bytes; i++)
      send_item(frame[i], i == 0 && (realign_next || $urandom_range(0, 3) == 0));
    realign_next = (n_bytes < 10);
  endtask

  // Random bytes with an occasional datagram start
  task automatic send_noise(input int n_bytes);
    for (int i = 0; i < n_bytes; i++)
      send_item(8'($urandom), $urandom_range(0, 9) == 0);
    realign_next = 1'b1;
  endtask

  function automatic logic [23:0] pick_speed();
    int r;
    r = $urandom_range(0, 9);
    if (r == 0) return '0;
    if (r == 1) return '1;
    return 24'($urandom);
  endfunction

  // Drop valid, wait for every expected record, then let the pipeline empty
  task automatic drain_and_settle();
    @(negedge clk);
    in_valid = 1'b0;
    while (expected_records.size() != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_register(input logic [cfcc_pkg::CFG_INDEX_W-1:0] idx,
                                input logic [cfcc_pkg::CFG_DATA_W-1:0] value);
    @(negedge clk);
    cfg_write_en = 1'b1;
    cfg_index = idx;
    cfg_data = value;
    @(negedge clk);
    cfg_write_en = 1'b0;
    cfg_data = cfcc_pkg::CFG_DATA_W'($urandom);
    if (idx == cfcc_pkg::CFG_IDX_FRAME_ID) cfg_frame_id = value;
    else if (idx == cfcc_pkg::CFG_IDX_STEP) cfg_step = value[7:0];
  endtask

  task automatic apply_settings(input logic [15:0] id, input logic [7:0] step);
    drain_and_settle();
    write_register(cfcc_pkg::CFG_IDX_FRAME_ID, id);
    // Upper data bits of the step write are don't-care
    write_register(cfcc_pkg::CFG_IDX_STEP, {8'($urandom), step});
    realign_next = 1'b1;
  endtask

  // Mostly well-formed frames on the accepted id, plus bad CRCs, foreign ids, cut frames and noise
  task automatic run_traffic(input int n_bytes);
    int          stop_at;
    int          pick;
    logic [24:0] target;
    stop_at = bytes_accepted + n_bytes;
    while (bytes_accepted < stop_at) begin
      pick = $urandom_range(0, 99);
      target = {1'b0, last_mileage} + 25'(cfg_step);
      if (pick < 45)
        send_frame(cfg_frame_id, target[23:0], pick_speed(), 1'b1, 10);
      else if (pick < 58)
        send_frame(cfg_frame_id, $urandom_range(0, 1) ? target[23:0] + 24'd1 :
                   target[23:0] - 24'd1, pick_speed(), 1'b1, 10);
      else if (pick < 68)
        send_frame(cfg_frame_id, 24'($urandom), pick_speed(), 1'b0, 10);
      else if (pick < 78)
        send_frame(cfg_frame_id ^ 16'($urandom_range(1, 65535)), target[23:0],
                   pick_speed(), 1'($urandom_range(0, 1)), 10);
      else if (pick < 90)
        send_frame(cfg_frame_id, target[23:0], pick_speed(), 1'b1, $urandom_range(1, 9));
      else
        send_noise($urandom_range(1, 15));
    end
  endtask

  task automatic test_directed_frames();
    // First good frame on the accepted id logs unconditionally
    send_frame(cfg_frame_id, FIRST_LOG_MILEAGE, '1, 1'b1, 10);
    // Bad CRC yields an error record with zeroed fields
    send_frame(cfg_frame_id, '1, '1, 1'b0, 10);
    // Cut a frame short; the next datagram start drops it
    send_frame(cfg_frame_id, '0, '0, 1'b1, 4);
  endtask

  task automatic test_spare_register_index();
    drain_and_settle();
    write_register(CFG_IDX_SPARE_LO, cfcc_pkg::CFG_DATA_W'($urandom));
    write_register(CFG_IDX_SPARE_HI, cfcc_pkg::CFG_DATA_W'($urandom));
    // Id and step must be unchanged: both frames log
    send_frame(cfg_frame_id, last_mileage + 24'(cfg_step), pick_speed(), 1'b1, 10);
    send_frame(cfg_frame_id, last_mileage + 24'(cfg_step), pick_speed(), 1'b1, 10);
  endtask

  task automatic test_reset_settings();
    run_traffic(180);
  endtask

  task automatic test_zero_settings();
    apply_settings(16'h0000, 8'd0);
    run_traffic(150);
  endtask

  task automatic test_random_settings();
    apply_settings(16'($urandom), 8'($urandom_range(1, 60)));
    run_traffic(220);
  endtask

  // Largest step drives the step sum past 24 bits late in this phase
  task automatic test_max_settings();
    apply_settings(16'hFFFF, 8'hFF);
    run_traffic(250);
  endtask

  // Output back-pressure: mostly ready, short and long stalls, calm stretches
  always @(negedge clk) begin : output_backpressure
    int r;
    if (recv_stall_left > 0) begin
      recv_stall_left--;
      out_ready = 1'b0;
    end else if (recv_calm_left > 0) begin
      recv_calm_left--;
      out_ready = 1'b1;
    end else begin
      r = $urandom_range(0, 99);
      if (r < 4) begin
        recv_calm_left = $urandom_range(20, 100);
        out_ready = 1'b1;
      end else if (r < 70) begin
        out_ready = 1'b1;
      end else if (r < 95) begin
        recv_stall_left = $urandom_range(0, 2);
        out_ready = 1'b0;
      end else begin
        recv_stall_left = $urandom_range(8, 40);
        out_ready = 1'b0;
      end
    end
  end

  // Compare each accepted result item with the oldest expected record
  always @(posedge clk) begin : record_checker
    cfcc_pkg::cfcc_out_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_records.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= MAX_REPORTS)
          $display("%0t: unexpected record kind=%0d mileage=%0d speed=%0d", $time,
                   out_data.record_kind, out_data.mileage_value, out_data.speed_tenths_kmh);
      end else begin
        want = expected_records.pop_front();
        if (out_data.record_kind !== want.record_kind ||
            out_data.mileage_value !== want.mileage_value ||
            out_data.speed_tenths_kmh !== want.speed_tenths_kmh) begin
          mismatch_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display({"%0t: record expected kind=%0d mileage=%0d speed=%0d,",
                      " got kind=%0d mileage=%0d speed=%0d"},
                     $time, want.record_kind, want.mileage_value, want.speed_tenths_kmh,
                     out_data.record_kind, out_data.mileage_value, out_data.speed_tenths_kmh);
        end
      end
    end
  end

  // Count cycles in which neither channel moves an item
  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin : watchdog
    wait (stall_cycles >= WATCHDOG_LIMIT);
    $display("can_frame_crc_check_and_log_filter_top: mismatch");
    $finish;
  end

  initial begin : test_sequence
    repeat (RESET_CYCLES) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed_frames();
    test_spare_register_index();
    test_reset_settings();
    test_zero_settings();
    test_random_settings();
    test_max_settings();
    drain_and_settle();
    if (mismatch_count == 0 && expected_records.size() == 0)
      $display("can_frame_crc_check_and_log_filter_top: match");
    else
      $display("can_frame_crc_check_and_log_filter_top: mismatch");
    $finish;
  end

endmodule
